// File: hw/rtl/ckb_pkg.sv
// Shared types and constants for the color keyed scaled blit.
package ckb_pkg;

	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int NUM_W   = COORD_W + DIM_W;
	localparam int QUO_W   = 13;
	localparam int IDX_W   = 2 * DIM_W + 1;
	localparam int ADDR_W  = 24;
	localparam int COLOR_W = 32;
	localparam int TIDX_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int FQ_DEPTH = 32;
	localparam int FQ_AW    = 5;

	typedef enum logic {
		MODE_LOAD   = 1'b0,
		MODE_RENDER = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DST_WIDTH  = 3'd0,
		REG_DST_HEIGHT = 3'd1,
		REG_SRC_WIDTH  = 3'd2,
		REG_SRC_HEIGHT = 3'd3,
		REG_SRC_STRIDE = 3'd4,
		REG_KEY_COLOR  = 3'd5
	} reg_idx_t;

	// Per-item data that rides alongside the mapping pipeline
	typedef struct packed {
		mode_t               mode;
		logic [TIDX_W-1:0]   tidx;
		logic [COLOR_W-1:0]  tcol;
		logic [ADDR_W-1:0]   addr;
		logic                inrange;
	} side_t;

	typedef struct packed {
		logic [DIM_W-1:0] dst_w;
		logic [DIM_W-1:0] dst_h;
		logic [DIM_W-1:0] src_w;
		logic [DIM_W-1:0] src_h;
		logic [DIM_W-1:0] stride;
	} geom_t;

endpackage

// File: hw/rtl/ckb_front.sv
// Front end: takes a transaction, forms address, range check and scale products.
module ckb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic                          mode,
	input  logic [ckb_pkg::TIDX_W-1:0]    texel_index,
	input  logic [ckb_pkg::COLOR_W-1:0]   texel_color,
	input  logic [ckb_pkg::COORD_W-1:0]   pixel_x,
	input  logic [ckb_pkg::COORD_W-1:0]   pixel_y,
	input  ckb_pkg::geom_t                geom,
	output logic                          valid_s1,
	output ckb_pkg::side_t                side_s1,
	output logic [ckb_pkg::NUM_W-1:0]     nrow_s1,
	output logic [ckb_pkg::NUM_W-1:0]     ncol_s1
);

	logic [ckb_pkg::NUM_W-1:0] yw;
	logic [ckb_pkg::NUM_W-1:0] addr_full;
	logic                      inr;

	assign yw        = ckb_pkg::NUM_W'(pixel_y) * ckb_pkg::NUM_W'(geom.dst_w);
	assign addr_full = yw + ckb_pkg::NUM_W'(pixel_x);
	assign inr       = ({1'b0, pixel_x} < geom.dst_w) && ({1'b0, pixel_y} < geom.dst_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			side_s1.mode    <= ckb_pkg::mode_t'(mode);
			side_s1.tidx    <= texel_index;
			side_s1.tcol    <= texel_color;
			side_s1.addr    <= addr_full[ckb_pkg::ADDR_W-1:0];
			side_s1.inrange <= inr;
			nrow_s1 <= ckb_pkg::NUM_W'(pixel_y) * ckb_pkg::NUM_W'(geom.src_h);
			ncol_s1 <= ckb_pkg::NUM_W'(pixel_x) * ckb_pkg::NUM_W'(geom.src_w);
		end
	end

endmodule

// File: hw/rtl/ckb_map.sv
// Mapping pipeline: two restoring dividers, one quotient bit per stage, then texel index.
module ckb_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ckb_pkg::geom_t                geom,
	input  logic                          valid_s1,
	input  ckb_pkg::side_t                side_s1,
	input  logic [ckb_pkg::NUM_W-1:0]     nrow_s1,
	input  logic [ckb_pkg::NUM_W-1:0]     ncol_s1,
	output logic                          valid_s15,
	output ckb_pkg::side_t                side_s15,
	output logic [ckb_pkg::IDX_W-1:0]     idx_s15
);

	localparam int NST = ckb_pkg::QUO_W;

	logic                          vld_s  [NST+1];
	ckb_pkg::side_t                side_s [NST+1];
	logic [ckb_pkg::NUM_W-1:0]     rnum_s [NST+1];
	logic [ckb_pkg::NUM_W-1:0]     cnum_s [NST+1];
	logic [ckb_pkg::DIM_W-1:0]     rrem_s [NST+1];
	logic [ckb_pkg::DIM_W-1:0]     crem_s [NST+1];
	logic [ckb_pkg::QUO_W-1:0]     rquo_s [NST+1];
	logic [ckb_pkg::QUO_W-1:0]     cquo_s [NST+1];

	assign vld_s[0]  = valid_s1;
	assign side_s[0] = side_s1;
	assign rnum_s[0] = nrow_s1;
	assign cnum_s[0] = ncol_s1;
	// quotient stays below 2^QUO_W, so the top bits start below the divisor
	assign rrem_s[0] = ckb_pkg::DIM_W'(nrow_s1[ckb_pkg::NUM_W-1:ckb_pkg::QUO_W]);
	assign crem_s[0] = ckb_pkg::DIM_W'(ncol_s1[ckb_pkg::NUM_W-1:ckb_pkg::QUO_W]);
	assign rquo_s[0] = '0;
	assign cquo_s[0] = '0;

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [ckb_pkg::DIM_W:0] rtry;
		logic [ckb_pkg::DIM_W:0] ctry;
		logic                    rge;
		logic                    cge;

		assign rtry = {rrem_s[k], rnum_s[k][NST-1-k]};
		assign ctry = {crem_s[k], cnum_s[k][NST-1-k]};
		assign rge  = rtry >= {1'b0, geom.dst_h};
		assign cge  = ctry >= {1'b0, geom.dst_w};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			rnum_s[k+1] <= rnum_s[k];
			cnum_s[k+1] <= cnum_s[k];
			rrem_s[k+1] <= rge ? ckb_pkg::DIM_W'(rtry - {1'b0, geom.dst_h})
				: rtry[ckb_pkg::DIM_W-1:0];
			crem_s[k+1] <= cge ? ckb_pkg::DIM_W'(ctry - {1'b0, geom.dst_w})
				: ctry[ckb_pkg::DIM_W-1:0];
			rquo_s[k+1] <= {rquo_s[k][ckb_pkg::QUO_W-2:0], rge};
			cquo_s[k+1] <= {cquo_s[k][ckb_pkg::QUO_W-2:0], cge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s15 <= 1'b0;
		end else begin
			valid_s15 <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		side_s15 <= side_s[NST];
		idx_s15  <= ckb_pkg::IDX_W'(rquo_s[NST]) * ckb_pkg::IDX_W'(geom.stride)
			+ ckb_pkg::IDX_W'(cquo_s[NST]);
	end

endmodule

// File: hw/rtl/ckb_back.sv
// Back end: texel store, color key test and result queue.
module ckb_back #(
	parameter int SRC_DEPTH = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ckb_pkg::COLOR_W-1:0]   key,
	input  logic                          valid_s15,
	input  ckb_pkg::side_t                side_s15,
	input  logic [ckb_pkg::IDX_W-1:0]     idx_s15,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ckb_pkg::ADDR_W-1:0]    dest_address,
	output logic [ckb_pkg::COLOR_W-1:0]   pixel_color,
	output logic                          write_enable
);

	localparam int AW = $clog2(SRC_DEPTH);

	logic [ckb_pkg::COLOR_W-1:0] mem [SRC_DEPTH];
	logic [ckb_pkg::COLOR_W-1:0] rd_q;

	logic                        push_s16;
	logic                        ok_s16;
	logic [ckb_pkg::ADDR_W-1:0]  addr_s16;

	logic wr_en;
	logic rd_ok;

	logic [ckb_pkg::ADDR_W-1:0]  fq_addr [ckb_pkg::FQ_DEPTH];
	logic [ckb_pkg::COLOR_W-1:0] fq_col  [ckb_pkg::FQ_DEPTH];
	logic                        fq_we   [ckb_pkg::FQ_DEPTH];
	logic [ckb_pkg::FQ_AW-1:0]   wp_q;
	logic [ckb_pkg::FQ_AW-1:0]   rp_q;
	logic [ckb_pkg::FQ_AW:0]     cnt_q;
	logic [ckb_pkg::COLOR_W-1:0] color;
	logic                        pop;

	assign wr_en = valid_s15 && (side_s15.mode == ckb_pkg::MODE_LOAD)
		&& (32'(side_s15.tidx) < 32'(SRC_DEPTH));
	assign rd_ok = side_s15.inrange && (32'(idx_s15) < 32'(SRC_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(side_s15.tidx)] <= side_s15.tcol;
		end
		rd_q <= mem[AW'(idx_s15)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s16 <= 1'b0;
		end else begin
			push_s16 <= valid_s15 && (side_s15.mode == ckb_pkg::MODE_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		ok_s16   <= rd_ok;
		addr_s16 <= side_s15.addr;
	end

	// out of range results carry color zero
	assign color = ok_s16 ? rd_q : '0;
	assign pop   = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_s16) begin
			fq_addr[wp_q] <= addr_s16;
			fq_col[wp_q]  <= color;
			fq_we[wp_q]   <= ok_s16 && (color != key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_s16) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (ckb_pkg::FQ_AW+1)'(push_s16) - (ckb_pkg::FQ_AW+1)'(pop);
		end
	end

	assign out_valid    = cnt_q != '0;
	assign dest_address = fq_addr[rp_q];
	assign pixel_color  = fq_col[rp_q];
	assign write_enable = fq_we[rp_q];

endmodule

// File: hw/rtl/color_keyed_scaled_blit.sv
// Top level of the color keyed nearest neighbor scaled blit.
//  channel | signals                                   | direction
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//  in      | in_valid in_ready mode texel_index ...    | in
//  out     | out_valid out_ready dest_address ...      | out
// One item per cycle while in_ready is high; out_valid rises once a render's result reaches the result queue.
// The path runs through the 13-stage divider pipeline plus multiply, index and store read.
// Reset drops all items in flight; the texel store keeps no reset value.
// in_ready falls only when 32 renders are outstanding in the pipeline and result queue.
module color_keyed_scaled_blit #(
	parameter int SRC_DEPTH = 65536,
	parameter int MAX_DIM   = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ckb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [ckb_pkg::TIDX_W-1:0]      texel_index,
	input  logic [ckb_pkg::COLOR_W-1:0]     texel_color,
	input  logic [ckb_pkg::COORD_W-1:0]     pixel_x,
	input  logic [ckb_pkg::COORD_W-1:0]     pixel_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ckb_pkg::ADDR_W-1:0]      dest_address,
	output logic [ckb_pkg::COLOR_W-1:0]     pixel_color,
	output logic                            write_enable
);

	ckb_pkg::geom_t              geom_q;
	logic [ckb_pkg::COLOR_W-1:0] key_q;
	logic [ckb_pkg::DIM_W-1:0]   dim_v;
	logic [ckb_pkg::FQ_AW:0]     pend_q;
	logic                        take;
	logic                        cfg_we;

	logic                        valid_s1;
	ckb_pkg::side_t              side_s1;
	logic [ckb_pkg::NUM_W-1:0]   nrow_s1;
	logic [ckb_pkg::NUM_W-1:0]   ncol_s1;
	logic                        valid_s15;
	ckb_pkg::side_t              side_s15;
	logic [ckb_pkg::IDX_W-1:0]   idx_s15;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign dim_v = ({1'b0, cfg_data[ckb_pkg::DIM_W-1:0]} > (ckb_pkg::DIM_W+1)'(MAX_DIM))
		? ckb_pkg::DIM_W'(MAX_DIM) : cfg_data[ckb_pkg::DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.dst_w  <= ckb_pkg::DIM_W'(640);
			geom_q.dst_h  <= ckb_pkg::DIM_W'(480);
			geom_q.src_w  <= ckb_pkg::DIM_W'(256);
			geom_q.src_h  <= ckb_pkg::DIM_W'(256);
			geom_q.stride <= ckb_pkg::DIM_W'(256);
			key_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ckb_pkg::REG_DST_WIDTH:  geom_q.dst_w  <= dim_v;
				ckb_pkg::REG_DST_HEIGHT: geom_q.dst_h  <= dim_v;
				ckb_pkg::REG_SRC_WIDTH:  geom_q.src_w  <= dim_v;
				ckb_pkg::REG_SRC_HEIGHT: geom_q.src_h  <= dim_v;
				ckb_pkg::REG_SRC_STRIDE: geom_q.stride <= dim_v;
				ckb_pkg::REG_KEY_COLOR:  key_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// credit: renders in flight plus queued never exceed the queue depth
	assign in_ready = pend_q < (ckb_pkg::FQ_AW+1)'(ckb_pkg::FQ_DEPTH);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (ckb_pkg::FQ_AW+1)'(take && mode)
				- (ckb_pkg::FQ_AW+1)'(out_valid && out_ready);
		end
	end

	ckb_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .mode(mode),
		.texel_index(texel_index), .texel_color(texel_color),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .geom(geom_q),
		.valid_s1(valid_s1), .side_s1(side_s1), .nrow_s1(nrow_s1), .ncol_s1(ncol_s1)
	);

	ckb_map u_map (
		.clk(clk), .arst_n(arst_n), .geom(geom_q),
		.valid_s1(valid_s1), .side_s1(side_s1), .nrow_s1(nrow_s1), .ncol_s1(ncol_s1),
		.valid_s15(valid_s15), .side_s15(side_s15), .idx_s15(idx_s15)
	);

	ckb_back #(.SRC_DEPTH(SRC_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .key(key_q),
		.valid_s15(valid_s15), .side_s15(side_s15), .idx_s15(idx_s15),
		.out_valid(out_valid), .out_ready(out_ready),
		.dest_address(dest_address), .pixel_color(pixel_color),
		.write_enable(write_enable)
	);

endmodule

// File: hw/rtl/ckb_checker.sv
// Port level checks for the blit, bound to the top level.
module ckb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          mode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ckb_pkg::ADDR_W-1:0]    dest_address,
	input logic [ckb_pkg::COLOR_W-1:0]   pixel_color,
	input logic                          write_enable
);

	logic [7:0] outst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			outst_q <= outst_q + 8'(in_valid && in_ready && mode)
				- 8'(out_valid && out_ready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dest_address)
		&& $stable(pixel_color) && $stable(write_enable))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outst_q != 8'd0)
		else $error("result without a pending render");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= 8'(ckb_pkg::FQ_DEPTH))
		else $error("outstanding renders exceed queue depth");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q < 8'(ckb_pkg::FQ_DEPTH) |-> in_ready)
		else $error("input stalled with credit left");

endmodule

bind color_keyed_scaled_blit ckb_checker u_ckb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.mode(mode), .out_valid(out_valid), .out_ready(out_ready),
	.dest_address(dest_address), .pixel_color(pixel_color),
	.write_enable(write_enable)
);
